@@ hdl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// Seven-segment chain refresh package
// Shared sizes, mode codes, segment constants, the glyph table and the
// command bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssc_pkg;

   // Number of digits on the chain and number of brightness slices.
   localparam int DIGITS = 6;
   localparam int SLICES = 16;

   // Derived widths.
   localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int LEVEL_W = $clog2(SLICES + 1);
   localparam int CMP_W   = 5;
   localparam int BIT_W   = 3;

   // Transaction modes.
   localparam logic [1:0] MODE_WRITE_DIGIT = 2'd0;
   localparam logic [1:0] MODE_SET_LEVEL   = 2'd1;
   localparam logic [1:0] MODE_SET_ALL     = 2'd2;
   localparam logic [1:0] MODE_EMIT_SLICE  = 2'd3;

   // Segment bit positions within a digit byte.
   localparam logic [7:0] SEG_A   = 8'h80;
   localparam logic [7:0] SEG_B   = 8'h40;
   localparam logic [7:0] SEG_C   = 8'h20;
   localparam logic [7:0] SEG_D   = 8'h10;
   localparam logic [7:0] SEG_E   = 8'h08;
   localparam logic [7:0] SEG_F   = 8'h04;
   localparam logic [7:0] SEG_G   = 8'h02;
   localparam logic [7:0] SEG_P   = 8'h01;
   localparam logic [7:0] SEG_BAD = SEG_A | SEG_C | SEG_E;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               write_char;
      logic               write_level;
      logic               write_all;
      logic               load_slice;
      logic               emit;
      logic [DIGIT_W-1:0] digit;
      logic [BIT_W-1:0]   bit_sel;
      logic               first;
      logic               last;
   } ssc_cmd_type;

   // Segment pattern for a character; unknown characters show segments A, C, E.
   function automatic logic [7:0] glyph_of(input logic [7:0] ch);
      logic [7:0] pat;
      case (ch)
         8'h20: pat = 8'h00;
         8'h2D: pat = SEG_G;
         8'h30: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         8'h31: pat = SEG_B | SEG_C;
         8'h32: pat = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
         8'h33: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
         8'h34: pat = SEG_B | SEG_C | SEG_F | SEG_G;
         8'h35, 8'h53, 8'h73: pat = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
         8'h36: pat = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         8'h37: pat = SEG_A | SEG_B | SEG_C;
         8'h38: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         8'h39: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         8'h41: pat = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
         8'h42: pat = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         8'h43: pat = SEG_A | SEG_D | SEG_E | SEG_F;
         8'h44, 8'h64: pat = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
         8'h45: pat = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
         8'h46: pat = SEG_A | SEG_E | SEG_F | SEG_G;
         8'h47: pat = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F;
         8'h48: pat = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
         8'h49, 8'h69: pat = SEG_E | SEG_F;
         8'h4C, 8'h6C: pat = SEG_D | SEG_E | SEG_F;
         8'h4E, 8'h6E: pat = SEG_C | SEG_E | SEG_G;
         8'h4F, 8'h6F: pat = SEG_C | SEG_D | SEG_E | SEG_G;
         8'h50, 8'h70: pat = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G;
         8'h52, 8'h72: pat = SEG_E | SEG_G;
         8'h54, 8'h74: pat = SEG_D | SEG_E | SEG_F | SEG_G;
         8'h55, 8'h75: pat = SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         default: pat = SEG_BAD;
      endcase
      return pat;
   endfunction

endpackage

@@ hdl/ssc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Seven-segment chain refresh controller
// Decodes transactions and walks the digit and bit counters of a slice.
// ----------------------------------------------------------------------------
module ssc_ctrl import ssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_digit_index,
   input  logic [3:0]  req_slice_index,
   output logic        busy,
   output ssc_cmd_type cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SHIFT = 1'b1;

   logic               state_ff, state_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic               accept;
   logic               index_ok;
   logic               slice_ok;

   assign busy     = (state_ff == ST_SHIFT);
   assign accept   = start && !busy;
   assign index_ok = ({1'b0, req_digit_index} < 4'(DIGITS));
   assign slice_ok = (CMP_W'(req_slice_index) < CMP_W'(SLICES));

   // Next state, counters and commands.
   always_comb begin
      state_in = state_ff;
      digit_in = digit_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      cmd.digit   = digit_ff;
      cmd.bit_sel = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_WRITE_DIGIT: cmd.write_char  = index_ok;
                  MODE_SET_LEVEL:   cmd.write_level = index_ok;
                  MODE_SET_ALL:     cmd.write_all   = 1'b1;
                  MODE_EMIT_SLICE: begin
                     if (slice_ok) begin
                        cmd.load_slice = 1'b1;
                        state_in       = ST_SHIFT;
                        digit_in       = DIGIT_W'(DIGITS - 1);
                        bit_in         = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SHIFT: begin
            cmd.emit  = 1'b1;
            cmd.first = (digit_ff == DIGIT_W'(DIGITS - 1)) && (bit_ff == '0);
            cmd.last  = (digit_ff == '0) && (bit_ff == '1);
            if (bit_ff == '1) begin
               bit_in = '0;
               if (digit_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  digit_in = digit_ff - 1'b1;
               end
            end else begin
               bit_in = bit_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register; the counters are loaded before each use.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      digit_ff <= digit_in;
      bit_ff   <= bit_in;
   end

endmodule

@@ hdl/ssc_dp.sv @@
// ----------------------------------------------------------------------------
// Seven-segment chain refresh datapath
// Holds characters, points and levels, and serializes digit patterns.
// ----------------------------------------------------------------------------
module ssc_dp import ssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ssc_cmd_type cmd,
   input  logic [2:0]  req_digit_index,
   input  logic [7:0]  req_char_code,
   input  logic        req_point_on,
   input  logic [7:0]  req_level,
   input  logic [3:0]  req_slice_index,
   output logic        rsp_valid,
   output logic        rsp_serial_bit,
   output logic        rsp_latch_high,
   output logic        rsp_last
);

   logic [7:0]         chars_ff [DIGITS];
   logic [LEVEL_W-1:0] levels_ff [DIGITS];
   logic [DIGITS-1:0]  points_ff;
   logic [3:0]         slice_ff;
   logic               valid_ff;
   logic               serial_ff, serial_in;
   logic               latch_ff;
   logic               last_ff;
   logic [DIGIT_W-1:0] waddr;
   logic [LEVEL_W-1:0] level_sat;
   logic               lit;
   logic [7:0]         pattern;

   assign waddr     = req_digit_index[DIGIT_W-1:0];
   assign level_sat = (req_level > 8'(SLICES)) ? LEVEL_W'(SLICES)
                                               : req_level[LEVEL_W-1:0];

   // Pattern of the digit being shifted and the selected bit, LSB first.
   always_comb begin
      lit     = (CMP_W'(slice_ff) < CMP_W'(levels_ff[cmd.digit]));
      pattern = '0;
      if (lit) begin
         pattern = glyph_of(chars_ff[cmd.digit]) |
                   {7'b0, points_ff[cmd.digit]};
      end
      serial_in = pattern[cmd.bit_sel];
   end

   // Digit storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < DIGITS; d++) begin
            chars_ff[d]  <= CHAR_SPACE;
            levels_ff[d] <= LEVEL_W'(SLICES);
         end
         points_ff <= '0;
      end else begin
         if (cmd.write_char) begin
            chars_ff[waddr]  <= req_char_code;
            points_ff[waddr] <= req_point_on;
         end
         if (cmd.write_level) begin
            levels_ff[waddr] <= level_sat;
         end
         if (cmd.write_all) begin
            for (int d = 0; d < DIGITS; d++) begin
               levels_ff[d] <= level_sat;
            end
         end
      end
   end

   // Slice under refresh.
   always_ff @(posedge clock) begin
      if (cmd.load_slice) begin
         slice_ff <= req_slice_index;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
      serial_ff <= serial_in;
      latch_ff  <= cmd.first;
      last_ff   <= cmd.last;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_serial_bit = serial_ff;
   assign rsp_latch_high = latch_ff;
   assign rsp_last       = last_ff;

endmodule

@@ hdl/seven_segment_chain_refresh_core.sv @@
// ----------------------------------------------------------------------------
// Seven-segment chain refresh core
// Digit, point and brightness store with a serial slice output for a chain
// of shift-register display drivers.
// ----------------------------------------------------------------------------
// Write transactions (modes 0 to 2) leave busy low.
// An emit-slice transaction keeps busy high while the controller's digit and
// bit counters walk all DIGITS*8 = 48 bits, one bit per cycle; each bit is
// selected in the shift state and reaches the result ports through the
// result register. The receiver cannot stall; each bit shows for one
// cycle with rsp_valid. Synchronous reset: digits space, points off, full levels.
module seven_segment_chain_refresh_core import ssc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [2:0] req_digit_index,
   input  logic [7:0] req_char_code,
   input  logic       req_point_on,
   input  logic [7:0] req_level,
   input  logic [3:0] req_slice_index,
   output logic       rsp_valid,
   output logic       rsp_serial_bit,
   output logic       rsp_latch_high,
   output logic       rsp_last
);

   ssc_cmd_type cmd;

   // Transaction decode and slice sequencing.
   ssc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_mode        (req_mode),
      .req_digit_index (req_digit_index),
      .req_slice_index (req_slice_index),
      .busy            (busy),
      .cmd             (cmd)
   );

   // Storage and serializer.
   ssc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_digit_index (req_digit_index),
      .req_char_code   (req_char_code),
      .req_point_on    (req_point_on),
      .req_level       (req_level),
      .req_slice_index (req_slice_index),
      .rsp_valid       (rsp_valid),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_high  (rsp_latch_high),
      .rsp_last        (rsp_last)
   );

   // A result bit only follows a cycle spent shifting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a slice in progress");

   // The end of a slice coincides with its final bit on the ports.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last))
      else $error("slice ended without its final bit");

   // An accepted emit with a valid slice starts shifting.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_EMIT_SLICE) &&
       (5'(req_slice_index) < 5'(SLICES))) |=> busy)
      else $error("valid slice request did not start shifting");

   // The latch pulse and the final bit never meet in a multi-bit slice.
   assert property (@(posedge clock) disable iff (reset)
      rsp_latch_high |-> (rsp_valid && !rsp_last))
      else $error("latch pulse on a wrong bit");

endmodule

@@ tb/sv/tb_seven_segment_chain_refresh_core.sv @@
// ----------------------------------------------------------------------------
// Seven-segment chain refresh core testbench
// Drives write, level and slice transactions through the start/busy command
// port. A shadow copy of the digit store computes the serial bit stream that
// each slice must produce, and every strobed bit is checked against it.
// ----------------------------------------------------------------------------
module tb_seven_segment_chain_refresh_core;
   import ssc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted transaction or strobed bit before giving up.
   localparam int STALL_LIMIT = 1000;
   localparam int CHAIN_BITS  = DIGITS * 8;

   // One serial bit of a refresh slice.
   typedef struct packed {
      logic serial_bit;
      logic latch_high;
      logic last;
   } chain_bit_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_mode = MODE_WRITE_DIGIT;
   logic [2:0] req_digit_index = '0;
   logic [7:0] req_char_code = '0;
   logic       req_point_on = 1'b0;
   logic [7:0] req_level = '0;
   logic [3:0] req_slice_index = '0;
   logic       rsp_valid;
   logic       rsp_serial_bit;
   logic       rsp_latch_high;
   logic       rsp_last;

   // Shadow copy of the digit store.
   logic [7:0]         shadow_chars[DIGITS];
   logic [DIGITS-1:0]  shadow_points;
   logic [LEVEL_W-1:0] shadow_levels[DIGITS];

   chain_bit_type pending_bits[$];
   int            error_count = 0;
   int            stall_count = 0;

   // Characters with a defined glyph, used to bias the random writes.
   string known_chars = " -0123456789ABCDEFGHILNOPRSTUdilnoprstu";

   seven_segment_chain_refresh_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_digit_index (req_digit_index),
      .req_char_code   (req_char_code),
      .req_point_on    (req_point_on),
      .req_level       (req_level),
      .req_slice_index (req_slice_index),
      .rsp_valid       (rsp_valid),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_high  (rsp_latch_high),
      .rsp_last        (rsp_last)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Segment byte shown for a character; anything without a glyph shows A, C, E.
   function automatic logic [7:0] segment_pattern(input logic [7:0] ch);
      logic [7:0] seg;
      case (ch)
         " ":           seg = 8'h00;
         "-":           seg = SEG_G;
         "0":           seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         "1":           seg = SEG_B | SEG_C;
         "2":           seg = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
         "3":           seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
         "4":           seg = SEG_B | SEG_C | SEG_F | SEG_G;
         "5", "S", "s": seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
         "6":           seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         "7":           seg = SEG_A | SEG_B | SEG_C;
         "8":           seg = 8'hFE;
         "9":           seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         "A":           seg = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
         "B":           seg = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         "C":           seg = SEG_A | SEG_D | SEG_E | SEG_F;
         "D", "d":      seg = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
         "E":           seg = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
         "F":           seg = SEG_A | SEG_E | SEG_F | SEG_G;
         "G":           seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F;
         "H":           seg = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
         "I", "i":      seg = SEG_E | SEG_F;
         "L", "l":      seg = SEG_D | SEG_E | SEG_F;
         "N", "n":      seg = SEG_C | SEG_E | SEG_G;
         "O", "o":      seg = SEG_C | SEG_D | SEG_E | SEG_G;
         "P", "p":      seg = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G;
         "R", "r":      seg = SEG_E | SEG_G;
         "T", "t":      seg = SEG_D | SEG_E | SEG_F | SEG_G;
         "U", "u":      seg = SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         default:       seg = SEG_A | SEG_C | SEG_E;
      endcase
      return seg;
   endfunction

   // Levels above the slice count light every slice.
   function automatic logic [LEVEL_W-1:0] saturate_level(input logic [7:0] lvl);
      return (lvl > SLICES) ? LEVEL_W'(SLICES) : LEVEL_W'(lvl);
   endfunction

   // Update the shadow store for one accepted transaction and queue the bits
   // that a slice transaction must shift out.
   task automatic predict_chain_bits(input logic [1:0] mode, input logic [2:0] idx,
                                     input logic [7:0] ch, input logic pt,
                                     input logic [7:0] lvl, input logic [3:0] slice);
      logic [7:0]    seg;
      chain_bit_type cb;
      int            n;
      n = 0;
      case (mode)
         MODE_WRITE_DIGIT: begin
            if (int'(idx) < DIGITS) begin
               shadow_chars[idx]  = ch;
               shadow_points[idx] = pt;
            end
         end
         MODE_SET_LEVEL: begin
            if (int'(idx) < DIGITS) shadow_levels[idx] = saturate_level(lvl);
         end
         MODE_SET_ALL: begin
            for (int d = 0; d < DIGITS; d++) shadow_levels[d] = saturate_level(lvl);
         end
         MODE_EMIT_SLICE: begin
            if (int'(slice) < SLICES) begin
               for (int d = DIGITS - 1; d >= 0; d--) begin
                  seg = 8'h00;
                  if (int'(slice) < int'(shadow_levels[d])) begin
                     seg = segment_pattern(shadow_chars[d]);
                     if (shadow_points[d]) seg = seg | SEG_P;
                  end
                  for (int b = 0; b < 8; b++) begin
                     cb.serial_bit = seg[b];
                     cb.latch_high = (n == 0);
                     cb.last       = (n == CHAIN_BITS - 1);
                     pending_bits.push_back(cb);
                     n++;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Track accepted transactions and check every strobed bit, in one process
   // so that queue updates at the same edge happen in a fixed order.
   always @(posedge clock) begin
      chain_bit_type want;
      if (reset) begin
         for (int d = 0; d < DIGITS; d++) begin
            shadow_chars[d]  = CHAR_SPACE;
            shadow_levels[d] = LEVEL_W'(SLICES);
         end
         shadow_points = '0;
      end else begin
         if (rsp_valid) begin
            if (pending_bits.size() == 0) begin
               $display("%0t: unexpected bit: expected none, actual bit=%b latch=%b last=%b",
                        $time, rsp_serial_bit, rsp_latch_high, rsp_last);
               error_count++;
            end else begin
               want = pending_bits.pop_front();
               if (rsp_serial_bit !== want.serial_bit) begin
                  $display("%0t: serial_bit mismatch: expected %b, actual %b",
                           $time, want.serial_bit, rsp_serial_bit);
                  error_count++;
               end
               if (rsp_latch_high !== want.latch_high) begin
                  $display("%0t: latch_high mismatch: expected %b, actual %b",
                           $time, want.latch_high, rsp_latch_high);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            predict_chain_bits(req_mode, req_digit_index, req_char_code,
                               req_point_on, req_level, req_slice_index);
      end
   end

   // Count cycles in which nothing moves on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
   end

   // Watchdog: the run has hung.
   initial begin
      wait (stall_count >= STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Present one transaction and hold it until the core takes it. Start stays
   // high on return so that back-to-back transactions follow without an idle gap.
   task automatic send_command(input logic [1:0] mode, input logic [2:0] idx,
                               input logic [7:0] ch, input logic pt,
                               input logic [7:0] lvl, input logic [3:0] slice);
      req_mode        <= mode;
      req_digit_index <= idx;
      req_char_code   <= ch;
      req_point_on    <= pt;
      req_level       <= lvl;
      req_slice_index <= slice;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a number of cycles.
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every queued bit has been seen.
   task automatic wait_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_bits.size() != 0) @(posedge clock);
   endtask

   task automatic emit_slice(input logic [3:0] slice);
      send_command(MODE_EMIT_SLICE, 3'd0, 8'h00, 1'b0, 8'h00, slice);
   endtask

   // After reset every digit is a space at full level, so slices are blank.
   task automatic test_reset_state();
      emit_slice(4'd0);
      emit_slice(4'd15);
      wait_drain();
   endtask

   // Character extremes, unknown glyphs, points, and ignored digit indices.
   task automatic test_glyphs();
      send_command(MODE_WRITE_DIGIT, 3'd0, 8'h00, 1'b1, 8'h00, 4'd0);
      send_command(MODE_WRITE_DIGIT, 3'd5, 8'hFF, 1'b1, 8'hFF, 4'd15);
      send_command(MODE_WRITE_DIGIT, 3'd1, "8",   1'b0, 8'h00, 4'd0);
      send_command(MODE_WRITE_DIGIT, 3'd2, "u",   1'b1, 8'h00, 4'd0);
      send_command(MODE_WRITE_DIGIT, 3'd3, "v",   1'b0, 8'h00, 4'd0);
      send_command(MODE_WRITE_DIGIT, 3'd4, "-",   1'b1, 8'h00, 4'd0);
      send_command(MODE_WRITE_DIGIT, 3'd6, "0",   1'b1, 8'h00, 4'd0);
      send_command(MODE_WRITE_DIGIT, 3'd7, "1",   1'b1, 8'h00, 4'd0);
      emit_slice(4'd15);
      wait_drain();
   endtask

   // Per-digit levels at zero, one and above the slice count.
   task automatic test_levels();
      send_command(MODE_SET_LEVEL, 3'd0, 8'h00, 1'b0, 8'd0,   4'd0);
      send_command(MODE_SET_LEVEL, 3'd5, 8'h00, 1'b0, 8'd255, 4'd0);
      send_command(MODE_SET_LEVEL, 3'd1, 8'h00, 1'b0, 8'd17,  4'd0);
      send_command(MODE_SET_LEVEL, 3'd2, 8'h00, 1'b0, 8'd1,   4'd0);
      send_command(MODE_SET_LEVEL, 3'd7, 8'h00, 1'b0, 8'd0,   4'd0);
      emit_slice(4'd0);
      emit_slice(4'd1);
      emit_slice(4'd15);
      wait_drain();
   endtask

   // Global level off, then back to full brightness.
   task automatic test_set_all();
      send_command(MODE_SET_ALL, 3'd0, 8'h00, 1'b0, 8'd0, 4'd0);
      emit_slice(4'd0);
      send_command(MODE_SET_ALL, 3'd3, 8'h00, 1'b0, 8'd16, 4'd0);
      emit_slice(4'd15);
      wait_drain();
   endtask

   // Random transactions sent in bursts with gaps of random length.
   task automatic test_random(input int count);
      logic [1:0] mode;
      logic [2:0] idx;
      logic [7:0] ch;
      logic [7:0] lvl;
      int         pick;
      int         burst_left;
      burst_left = $urandom_range(1, 16);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      mode = MODE_EMIT_SLICE;
         else if (pick < 70) mode = MODE_WRITE_DIGIT;
         else if (pick < 90) mode = MODE_SET_LEVEL;
         else                mode = MODE_SET_ALL;
         // Mostly digits that exist, sometimes the unused indices.
         idx = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, DIGITS - 1))
                                            : 3'($urandom_range(0, 7));
         ch  = ($urandom_range(0, 99) < 70)
               ? known_chars[$urandom_range(0, known_chars.len() - 1)]
               : 8'($urandom_range(0, 255));
         lvl = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, SLICES + 1))
                                            : 8'($urandom_range(0, 255));
         send_command(mode, idx, ch, 1'($urandom_range(0, 1)), lvl,
                      4'($urandom_range(0, 15)));
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            // Short gaps are common; long ones can straddle a whole slice.
            idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(1, 60)
                                                    : $urandom_range(1, 6));
         end
      end
      wait_drain();
   endtask

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_glyphs();
      test_levels();
      test_set_all();
      test_random(500);
      // Let any stray bits surface before the verdict.
      repeat (CHAIN_BITS + 12) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
